// ===== rtl/escape_key_decoder_cursor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape key decoder checker
// Immediate-implication and next-cycle-implication forms, clocked and reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_KEY_DECODER_CURSOR_ASSERT_SVH
`define ESCAPE_KEY_DECODER_CURSOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define EKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ekd assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent
`define EKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ekd assertion failed (next cycle)");

`endif

// ===== rtl/ekd_pkg.sv =====
// ----------------------------------------------------------------------------
// ekd_pkg
// Shared types and constants of the escape key decoder with cursor.
// ----------------------------------------------------------------------------
package ekd_pkg;

  // Key codes on the result channel
  localparam logic [8:0] KEY_ESC   = 9'd27;
  localparam logic [8:0] KEY_LEFT  = 9'd256;
  localparam logic [8:0] KEY_RIGHT = 9'd257;
  localparam logic [8:0] KEY_UP    = 9'd258;
  localparam logic [8:0] KEY_DOWN  = 9'd259;
  localparam logic [8:0] KEY_PGUP  = 9'd260;
  localparam logic [8:0] KEY_PGDN  = 9'd261;
  localparam logic [8:0] KEY_DEL   = 9'd262;

  // Received characters of interest
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_TILDE    = 8'h7e;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_1        = 8'h31;
  localparam logic [7:0] CH_3        = 8'h33;
  localparam logic [7:0] CH_5        = 8'h35;
  localparam logic [7:0] CH_6        = 8'h36;
  localparam logic [7:0] CH_9        = 8'h39;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'd1;

  // Reset screen size
  localparam logic [9:0] ROWS_RESET = 10'd24;
  localparam logic [9:0] COLS_RESET = 10'd80;

  // Input item
  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic [8:0] key_code;
    logic [9:0] cursor_x;
    logic [9:0] cursor_y;
  } out_t;

  // Parser to cursor: decoded key event
  typedef struct packed {
    logic       have;
    logic [8:0] code;
  } key_ev_t;

  // Cursor position
  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
  } pos_t;

endpackage

// ===== rtl/ekd_parser.sv =====
// ----------------------------------------------------------------------------
// ekd_parser
// Escape sequence parser: turns bytes and timeouts into zero or one key.
// ----------------------------------------------------------------------------
module ekd_parser import ekd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  in_t     item,
  output key_ev_t key_ev
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_SECOND,
    PH_DIGIT
  } phase_t;

  // Only the digits that can complete a key are worth remembering
  typedef enum logic [1:0] {
    DG_OTHER,
    DG_DEL,
    DG_PGUP,
    DG_PGDN
  } digit_t;

  phase_t     phase_r, phase_nxt;
  logic       bracket_r, bracket_nxt;
  digit_t     digit_r, digit_nxt;
  logic [7:0] b;

  assign b = item.in_byte;

  // Next parse state and decoded key
  always_comb begin
    phase_nxt   = phase_r;
    bracket_nxt = bracket_r;
    digit_nxt   = digit_r;
    key_ev.have = 1'b0;
    key_ev.code = KEY_ESC;
    if (item.mode) begin
      // timeout: abandon any sequence in progress
      key_ev.have = (phase_r != PH_IDLE);
      phase_nxt   = PH_IDLE;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (b == CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            key_ev.have = 1'b1;
            key_ev.code = {1'b0, b};
          end
        end
        PH_ESC: begin
          bracket_nxt = (b == CH_LBRACKET);
          phase_nxt   = PH_SECOND;
        end
        PH_SECOND: begin
          key_ev.have = 1'b1;
          phase_nxt   = PH_IDLE;
          if (bracket_r) begin
            case (b)
              CH_A: key_ev.code = KEY_UP;
              CH_B: key_ev.code = KEY_DOWN;
              CH_C: key_ev.code = KEY_RIGHT;
              CH_D: key_ev.code = KEY_LEFT;
              default: begin
                if (b inside {[CH_1:CH_9]}) begin
                  key_ev.have = 1'b0;
                  phase_nxt   = PH_DIGIT;
                  case (b)
                    CH_3:    digit_nxt = DG_DEL;
                    CH_5:    digit_nxt = DG_PGUP;
                    CH_6:    digit_nxt = DG_PGDN;
                    default: digit_nxt = DG_OTHER;
                  endcase
                end
              end
            endcase
          end
        end
        default: begin
          // third byte after ESC [ digit
          key_ev.have = 1'b1;
          phase_nxt   = PH_IDLE;
          if (b == CH_TILDE) begin
            case (digit_r)
              DG_DEL:  key_ev.code = KEY_DEL;
              DG_PGUP: key_ev.code = KEY_PGUP;
              DG_PGDN: key_ev.code = KEY_PGDN;
              default: key_ev.code = KEY_ESC;
            endcase
          end
        end
      endcase
    end
  end

  // Parse state, advanced once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bracket_r <= 1'b0;
      digit_r   <= DG_OTHER;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bracket_r <= bracket_nxt;
      digit_r   <= digit_nxt;
    end
  end

endmodule

// ===== rtl/ekd_cursor.sv =====
// ----------------------------------------------------------------------------
// ekd_cursor
// Cursor position, moved by decoded keys and clamped to the screen size.
// ----------------------------------------------------------------------------
module ekd_cursor import ekd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [8:0] key_code,
  input  logic [9:0] screen_rows,
  input  logic [9:0] screen_cols,
  output pos_t       pos_nxt
);

  pos_t        pos_r;
  logic [9:0]  last_col;
  logic [9:0]  last_row;
  logic [10:0] x_inc;
  logic [10:0] y_inc;

  // A zero size counts as one
  assign last_col = (screen_cols == 10'd0) ? 10'd0 : screen_cols - 10'd1;
  assign last_row = (screen_rows == 10'd0) ? 10'd0 : screen_rows - 10'd1;
  assign x_inc    = {1'b0, pos_r.x} + 11'd1;
  assign y_inc    = {1'b0, pos_r.y} + 11'd1;

  // Position after the key
  always_comb begin
    pos_nxt = pos_r;
    case (key_code)
      KEY_LEFT:  pos_nxt.x = (pos_r.x != 10'd0) ? pos_r.x - 10'd1 : 10'd0;
      KEY_RIGHT: pos_nxt.x = (x_inc < {1'b0, last_col}) ? x_inc[9:0] : last_col;
      KEY_UP:    pos_nxt.y = (pos_r.y != 10'd0) ? pos_r.y - 10'd1 : 10'd0;
      KEY_DOWN:  pos_nxt.y = (y_inc < {1'b0, last_row}) ? y_inc[9:0] : last_row;
      KEY_PGUP:  pos_nxt.y = 10'd0;
      KEY_PGDN:  pos_nxt.y = last_row;
      default:   pos_nxt = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/escape_key_decoder_cursor.sv =====
// ----------------------------------------------------------------------------
// escape_key_decoder_cursor
// Each item goes from the input register to the result register, which holds any key.
// Throughput: one item per cycle unless a result is held; parser and cursor in one pass.
// Reset (synchronous): parser idle, cursor at 0,0, screen 24 rows by 80 columns.
// ----------------------------------------------------------------------------
module escape_key_decoder_cursor import ekd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [9:0]           cfg_data
);

  logic       in_valid_r;
  in_t        in_data_r;
  logic       out_valid_r;
  out_t       out_data_r;
  logic [9:0] rows_r;
  logic [9:0] cols_r;
  logic       go;
  logic       emit;
  key_ev_t    key_ev;
  pos_t       pos_nxt;

  // The held item moves on when the result register is free or being drained
  assign go       = in_valid_r && (!out_valid_r || out_ready);
  assign emit     = go && key_ev.have;
  assign in_ready = !in_valid_r || go;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ekd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (go),
    .item   (in_data_r),
    .key_ev (key_ev)
  );

  ekd_cursor u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (emit),
    .key_code    (key_ev.code),
    .screen_rows (rows_r),
    .screen_cols (cols_r),
    .pos_nxt     (pos_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_ROWS: rows_r <= cfg_data;
        CFG_SCREEN_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= key_ev.have;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.key_code <= key_ev.code;
      out_data_r.cursor_x <= pos_nxt.x;
      out_data_r.cursor_y <= pos_nxt.y;
    end
  end

endmodule

// ===== rtl/ekd_checker.sv =====
// ----------------------------------------------------------------------------
// ekd_checker
// Port-level checks of the escape key decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "escape_key_decoder_cursor_assert.svh"

module ekd_checker import ekd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic [9:0] last_x_r;
  logic [9:0] last_y_r;
  logic       plain_key;
  logic       pgup_key;
  logic       cursor_same;

  // Cursor shown by the last result transfer; it starts at the origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= 10'd0;
      last_y_r <= 10'd0;
    end else if (out_valid && out_ready) begin
      last_x_r <= out_data.cursor_x;
      last_y_r <= out_data.cursor_y;
    end
  end

  // Plain bytes, ESC and delete leave the cursor where it was
  assign plain_key = (out_data.key_code < KEY_LEFT) || (out_data.key_code == KEY_DEL);
  assign pgup_key  = out_valid && (out_data.key_code == KEY_PGUP);
  assign cursor_same = (out_data.cursor_x == last_x_r) && (out_data.cursor_y == last_y_r);

  `EKD_ASSERT_NOW(a_key_range, clk, rst_n, out_valid, out_data.key_code <= KEY_DEL)
  `EKD_ASSERT_NOW(a_pgup_top, clk, rst_n, pgup_key, out_data.cursor_y == 10'd0)
  `EKD_ASSERT_NOW(a_plain_still, clk, rst_n, out_valid && plain_key, cursor_same)
  `EKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind escape_key_decoder_cursor ekd_checker u_ekd_checker (.*);

// ===== sim/tb_escape_key_decoder_cursor.sv =====
// ----------------------------------------------------------------------------
// tb_escape_key_decoder_cursor
// Drives terminal bytes and read timeouts into the escape key decoder and
// checks each decoded key and cursor position against an in-bench decoder.
// A short table of keys and broken sequences runs first. Random traffic
// follows under several screen sizes, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_escape_key_decoder_cursor;
  import ekd_pkg::*;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;
  localparam int   DRAIN_LIMIT  = 5000;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_AFTER_ESC,
    SEQ_SECOND,
    SEQ_DIGIT
  } seq_phase_t;

  typedef struct packed {
    logic mode;
    logic [7:0] ch;
    logic typed;
    out_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_ROWS;
  logic [9:0]           cfg_data = '0;

  // typed expectation riding along with the current input item
  logic dir_typed = 1'b0;
  out_t dir_want = '0;

  // decoder mirror: parser, cursor and screen size
  seq_phase_t sq_phase = SEQ_IDLE;
  logic       sq_bracket = 1'b0;
  logic [7:0] sq_digit = '0;
  int         cur_col = 0;
  int         cur_row = 0;
  int         scr_rows = int'(ROWS_RESET);
  int         scr_cols = int'(COLS_RESET);

  out_t pending_keys[$];
  int   fail_count = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_sent = 0;
  int   n_sizes = 1;
  int   burst_left = 0;

  logic [15:0] stall_pat = 16'hffff;
  logic [3:0]  stall_idx = '0;

  escape_key_decoder_cursor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still due", $time, pending_keys.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Move the cursor for one decoded key, clamped to the screen
  function automatic void move_cursor(input logic [8:0] key);
    int last_c;
    int last_r;
    last_c = (scr_cols == 0) ? 0 : scr_cols - 1;
    last_r = (scr_rows == 0) ? 0 : scr_rows - 1;
    case (key)
      KEY_LEFT:  cur_col = (cur_col > 0) ? cur_col - 1 : 0;
      KEY_RIGHT: cur_col = (cur_col + 1 < last_c) ? cur_col + 1 : last_c;
      KEY_UP:    cur_row = (cur_row > 0) ? cur_row - 1 : 0;
      KEY_DOWN:  cur_row = (cur_row + 1 < last_r) ? cur_row + 1 : last_r;
      KEY_PGUP:  cur_row = 0;
      KEY_PGDN:  cur_row = last_r;
      default: ;
    endcase
  endfunction

  // Decode one event; emits is set when a key comes out
  function automatic void decode_key(input in_t ev, output logic emits, output out_t res);
    logic [8:0] key;
    key = KEY_ESC;
    emits = 1'b0;
    if (ev.mode == MODE_TIMEOUT) begin
      // timeout aborts a sequence, ignored when idle
      if (sq_phase != SEQ_IDLE) begin
        emits = 1'b1;
        sq_phase = SEQ_IDLE;
      end
    end else begin
      case (sq_phase)
        SEQ_IDLE: begin
          if (ev.in_byte == CH_ESC) begin
            sq_phase = SEQ_AFTER_ESC;
          end else begin
            key = {1'b0, ev.in_byte};
            emits = 1'b1;
          end
        end
        SEQ_AFTER_ESC: begin
          sq_bracket = (ev.in_byte == CH_LBRACKET);
          sq_phase = SEQ_SECOND;
        end
        SEQ_SECOND: begin
          emits = 1'b1;
          sq_phase = SEQ_IDLE;
          if (sq_bracket) begin
            if (ev.in_byte == CH_A) key = KEY_UP;
            else if (ev.in_byte == CH_B) key = KEY_DOWN;
            else if (ev.in_byte == CH_C) key = KEY_RIGHT;
            else if (ev.in_byte == CH_D) key = KEY_LEFT;
            else if (ev.in_byte >= CH_1 && ev.in_byte <= CH_9) begin
              sq_digit = ev.in_byte;
              sq_phase = SEQ_DIGIT;
              emits = 1'b0;
            end
          end
        end
        default: begin
          // third byte always closes the sequence
          emits = 1'b1;
          sq_phase = SEQ_IDLE;
          if (ev.in_byte == CH_TILDE) begin
            if (sq_digit == CH_3) key = KEY_DEL;
            else if (sq_digit == CH_5) key = KEY_PGUP;
            else if (sq_digit == CH_6) key = KEY_PGDN;
          end
        end
      endcase
    end
    if (emits) move_cursor(key);
    res.key_code = key;
    res.cursor_x = cur_col[9:0];
    res.cursor_y = cur_row[9:0];
  endfunction

  // Observe transfers: track config writes, predict inputs, check results
  always @(posedge clk) begin
    logic emits;
    out_t pred;
    out_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCREEN_ROWS) scr_rows = int'(cfg_data);
        else if (cfg_index == CFG_SCREEN_COLS) scr_cols = int'(cfg_data);
      end
      if (in_valid && in_ready) begin
        n_in++;
        decode_key(in_data, emits, pred);
        if (dir_typed) pending_keys.push_back(dir_want);
        else if (emits) pending_keys.push_back(pred);
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (pending_keys.size() == 0) begin
          $display("%0t: unexpected result, expected none, got key %0d at %0d,%0d",
                   $time, out_data.key_code, out_data.cursor_x, out_data.cursor_y);
          fail_count++;
        end else begin
          want = pending_keys.pop_front();
          if (out_data.key_code !== want.key_code) begin
            $display("%0t: key_code mismatch, expected %0d, got %0d",
                     $time, want.key_code, out_data.key_code);
            fail_count++;
          end
          if (out_data.cursor_x !== want.cursor_x) begin
            $display("%0t: cursor_x mismatch, expected %0d, got %0d",
                     $time, want.cursor_x, out_data.cursor_x);
            fail_count++;
          end
          if (out_data.cursor_y !== want.cursor_y) begin
            $display("%0t: cursor_y mismatch, expected %0d, got %0d",
                     $time, want.cursor_y, out_data.cursor_y);
            fail_count++;
          end
        end
      end
    end
  end

  // Sink stalls on a rotating pattern, reloaded each time the pattern index wraps
  always @(posedge clk) begin
    out_ready <= stall_pat[stall_idx];
    if (stall_idx == 4'd15) begin
      stall_idx <= '0;
      if ($urandom_range(0, 3) == 0) stall_pat <= 16'hffff;
      else stall_pat <= 16'($urandom()) | 16'h0101;
    end else begin
      stall_idx <= stall_idx + 4'd1;
    end
  end

  // Hold one item until the transfer completes, then pace the burst
  task automatic send_item(input in_t it, input logic typed, input out_t want);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    dir_typed <= typed;
    dir_want <= want;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 64)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_ev(input logic mode, input logic [7:0] ch);
    send_item(in_t'{mode, ch}, 1'b0, '0);
  endtask

  // Wait until every due result has arrived and the pipeline has flushed
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_keys.size() != 0) begin
      $display("%0t: %0d results never arrived, next expected key %0d",
               $time, pending_keys.size(), pending_keys[0].key_code);
      fail_count += pending_keys.size();
      pending_keys.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_screen(input logic [9:0] rows, input logic [9:0] cols);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SCREEN_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_sizes++;
  endtask

  // Mostly well-formed sequences, plus plain bytes, timeouts and broken ones
  task automatic random_traffic(input int count);
    int stop_at;
    int pick;
    int op;
    logic [7:0] digit;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        op = $urandom_range(0, 6);
        send_ev(MODE_BYTE, CH_ESC);
        send_ev(MODE_BYTE, CH_LBRACKET);
        case (op)
          0: send_ev(MODE_BYTE, CH_A);
          1: send_ev(MODE_BYTE, CH_B);
          2: send_ev(MODE_BYTE, CH_C);
          3: send_ev(MODE_BYTE, CH_D);
          default: begin
            digit = (op == 4) ? CH_3 : (op == 5) ? CH_5 : CH_6;
            send_ev(MODE_BYTE, digit);
            send_ev(MODE_BYTE, CH_TILDE);
          end
        endcase
      end else if (pick < 82) begin
        send_ev(MODE_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        send_ev(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
      end else begin
        send_ev(MODE_BYTE, CH_ESC);
        case ($urandom_range(0, 3))
          0: begin
            send_ev(MODE_BYTE, 8'($urandom_range(0, 255)));
            send_ev(MODE_BYTE, 8'($urandom_range(0, 255)));
          end
          1: begin
            send_ev(MODE_BYTE, CH_LBRACKET);
            send_ev(MODE_BYTE, 8'($urandom_range(0, 255)));
          end
          2: begin
            send_ev(MODE_BYTE, CH_LBRACKET);
            send_ev(MODE_BYTE, 8'($urandom_range(CH_1, CH_9)));
            if ($urandom_range(0, 1) == 0) send_ev(MODE_BYTE, CH_TILDE);
            else send_ev(MODE_BYTE, 8'($urandom_range(0, 255)));
          end
          default: begin
            if ($urandom_range(0, 1) == 0) send_ev(MODE_BYTE, CH_LBRACKET);
            send_ev(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  // Directed table, starting from reset: 24 rows by 80 columns, cursor at 0,0
  dir_row_t key_table [0:33] = '{
    '{MODE_BYTE,    8'h00,       1'b1, '{9'd0,   10'd0, 10'd0}},
    '{MODE_BYTE,    8'hff,       1'b1, '{9'd255, 10'd0, 10'd0}},
    '{MODE_TIMEOUT, 8'h00,       1'b0, '0},   // idle timeout: nothing
    // left and up at the origin stay put
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_D,        1'b1, '{KEY_LEFT, 10'd0, 10'd0}},
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_A,        1'b1, '{KEY_UP, 10'd0, 10'd0}},
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_C,        1'b0, '0},
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_B,        1'b0, '0},
    // page down, page up, delete
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_6,        1'b0, '0},
    '{MODE_BYTE,    CH_TILDE,    1'b0, '0},
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_5,        1'b0, '0},
    '{MODE_BYTE,    CH_TILDE,    1'b0, '0},
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_3,        1'b0, '0},
    '{MODE_BYTE,    CH_TILDE,    1'b0, '0},
    // ESC inside a sequence, no bracket: yields ESC
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_TILDE,    1'b0, '0},
    // timeout after a digit: yields ESC
    '{MODE_BYTE,    CH_ESC,      1'b0, '0},
    '{MODE_BYTE,    CH_LBRACKET, 1'b0, '0},
    '{MODE_BYTE,    CH_5,        1'b0, '0},
    '{MODE_TIMEOUT, 8'hff,       1'b0, '0}
  };

  initial begin
    logic [9:0] rows_pick;
    logic [9:0] cols_pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (key_table[i])
      send_item(in_t'{key_table[i].mode, key_table[i].ch}, key_table[i].typed,
                key_table[i].want);
    drain();

    // screen sizes: minimum, zero, maximum, shrinks below the cursor, random
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin rows_pick = 10'd1;    cols_pick = 10'd1;    end
        1: begin rows_pick = 10'd0;    cols_pick = 10'd0;    end
        2: begin rows_pick = 10'd1023; cols_pick = 10'd1023; end
        3: begin rows_pick = 10'd30;   cols_pick = 10'd40;   end
        4: begin rows_pick = 10'd4;    cols_pick = 10'd3;    end
        5: begin rows_pick = 10'd2;    cols_pick = 10'd1023; end
        6: begin rows_pick = 10'd1023; cols_pick = 10'd2;    end
        default: begin
          rows_pick = 10'($urandom_range(1, 1023));
          cols_pick = 10'($urandom_range(1, 40));
        end
      endcase
      write_screen(rows_pick, cols_pick);
      random_traffic(145);
      drain();
    end

    $display("Sent %0d input transfers over %0d screen sizes; checked %0d key results.",
             n_in, n_sizes, n_out);
    $display("Covered arrows, paging, delete, plain bytes, timeouts and broken sequences.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
